>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int CAP_W   = 5;
    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 5;
    localparam int ITEM_W  = 32;

    localparam logic [ITEM_W-1:0] ITEM_NONE = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_PEEK       = 3'd4
    } t_req;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic               ok;
        logic [TOTAL_W-1:0] item_total;
        logic               is_empty;
        logic               is_full;
    } t_stat;

endpackage

>>> rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended ring buffer of signed words with a programmable capacity.
// ----------------------------------------------------------------------------
// Request channel (i_in_valid / o_in_ready) carries i_req_type and i_value:
// push front, push rear, pop front, pop rear or peek. Each request beat
// yields one result beat on (o_out_valid / i_out_ready): success flag,
// item count, empty/full flags and the front and rear items after the
// update (-1 when empty).
// The update and read issue in the accept cycle, the registered read data
// forms the result in the next, and the result is loaded into the output
// register once that register is free. A new request is taken only after
// the last result has moved into the output register.
// A write on i_cfg_we sets the capacity (0 reads as 1, above DEPTH as
// DEPTH) and empties the deque; write it only while no request is open.
// Reset: capacity DEPTH, deque empty, no result pending.
// Receiver stall: one result waits in the output register; the next one
// waits inside the block and o_in_ready stays low until it moves on.
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_capacity,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_ok,
    output logic [TOTAL_W-1:0] o_item_total,
    output logic               o_is_empty,
    output logic               o_is_full,
    output logic [ITEM_W-1:0]  o_front_item,
    output logic [ITEM_W-1:0]  o_rear_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                 we, re;
    logic [AW-1:0]        waddr, raddr_front, raddr_rear;
    logic [WORD_BITS-1:0] wdata, rdata_front, rdata_rear;
    logic                 resp_valid, resp_take, load;
    t_stat                resp_stat;
    logic [ITEM_W-1:0]    resp_front, resp_rear;

    logic                 r_out_valid;
    t_stat                r_out_stat;
    logic [ITEM_W-1:0]    r_out_front, r_out_rear;

    cdq_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (re),
        .i_raddr_a (raddr_front),
        .i_raddr_b (raddr_rear),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_rear)
    );

    cdq_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_capacity (i_cfg_capacity),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .o_resp_valid   (resp_valid),
        .i_resp_take    (resp_take),
        .o_stat         (resp_stat),
        .o_front_item   (resp_front),
        .o_rear_item    (resp_rear),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_re           (re),
        .o_raddr_front  (raddr_front),
        .o_raddr_rear   (raddr_rear),
        .i_rdata_front  (rdata_front),
        .i_rdata_rear   (rdata_rear)
    );

    assign resp_take = !r_out_valid || i_out_ready;
    assign load      = resp_valid && resp_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_stat  <= resp_stat;
            r_out_front <= resp_front;
            r_out_rear  <= resp_rear;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_out_stat.ok;
    assign o_item_total = r_out_stat.item_total;
    assign o_is_empty   = r_out_stat.is_empty;
    assign o_is_full    = r_out_stat.is_full;
    assign o_front_item = r_out_front;
    assign o_rear_item  = r_out_rear;

endmodule

>>> rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Slot storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int AW        = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr_a,
    input  logic [AW-1:0]        i_raddr_b,
    output logic [WORD_BITS-1:0] o_rdata_a,
    output logic [WORD_BITS-1:0] o_rdata_b
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata_a;
    logic [WORD_BITS-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Index and count update, slot write, front/rear read with forwarding.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int AW        = 4,
    parameter int CW        = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_capacity,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [VALUE_W-1:0]   i_value,
    output logic                 o_resp_valid,
    input  logic                 i_resp_take,
    output t_stat                o_stat,
    output logic [ITEM_W-1:0]    o_front_item,
    output logic [ITEM_W-1:0]    o_rear_item,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [WORD_BITS-1:0] o_wdata,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr_front,
    output logic [AW-1:0]        o_raddr_rear,
    input  logic [WORD_BITS-1:0] i_rdata_front,
    input  logic [WORD_BITS-1:0] i_rdata_rear
);

    localparam int XW = AW + 1;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cap;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_count, n_count;
    t_stat                r_stat, n_stat;
    logic [WORD_BITS-1:0] r_fwd_word;
    logic                 r_fwd_front, r_fwd_rear;

    logic                 acc;
    logic                 n_ok;
    logic [CW-1:0]        cfg_cap;
    logic [63:0]          val_ext;
    logic [WORD_BITS-1:0] in_word;
    logic [31:0]          count_ext;
    logic [WORD_BITS-1:0] front_word, rear_word;
    logic [63:0]          front_ext, rear_ext;

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx,
                                              input logic [CW-1:0] cap);
        logic [XW-1:0] nxt;
        nxt = XW'(idx) + XW'(1);
        return (nxt >= XW'(cap)) ? '0 : nxt[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx,
                                                input logic [CW-1:0] cap);
        logic [XW-1:0] prv;
        prv = (idx == '0) ? (XW'(cap) - XW'(1)) : (XW'(idx) - XW'(1));
        return prv[AW-1:0];
    endfunction

    always_comb begin
        if (i_cfg_capacity == '0) begin
            cfg_cap = CW'(1);
        end else if ({27'b0, i_cfg_capacity} > 32'(DEPTH)) begin
            cfg_cap = CW'(DEPTH);
        end else begin
            cfg_cap = CW'(i_cfg_capacity);
        end
    end

    assign val_ext    = {32'b0, i_value};
    assign in_word    = val_ext[WORD_BITS-1:0];
    assign acc        = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_ok    = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_head;
        case (t_req'(i_req_type))
            REQ_PUSH_FRONT: begin
                if (r_count < r_cap) begin
                    o_we    = acc;
                    o_waddr = r_head;
                    n_head  = step_down(r_head, r_cap);
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            REQ_PUSH_REAR: begin
                if (r_count < r_cap) begin
                    o_we    = acc;
                    o_waddr = r_tail;
                    n_tail  = step_up(r_tail, r_cap);
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (r_count != '0) begin
                    n_head  = step_up(r_head, r_cap);
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            REQ_POP_REAR: begin
                if (r_count != '0) begin
                    n_tail  = step_down(r_tail, r_cap);
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            REQ_PEEK: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    assign o_wdata       = in_word;
    assign o_re          = acc;
    assign o_raddr_front = step_up(n_head, r_cap);
    assign o_raddr_rear  = step_down(n_tail, r_cap);
    assign count_ext     = 32'(n_count);

    always_comb begin
        n_stat.ok         = n_ok;
        n_stat.item_total = count_ext[TOTAL_W-1:0];
        n_stat.is_empty   = (n_count == '0);
        n_stat.is_full    = (n_count == r_cap);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_resp_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CW'(DEPTH);
            r_head  <= AW'(DEPTH - 1);
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap   <= cfg_cap;
                r_head  <= AW'(cfg_cap - CW'(1));
                r_tail  <= '0;
                r_count <= '0;
            end else if (acc) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    // same-cycle write to a slot being read: take the written word
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_stat      <= n_stat;
            r_fwd_word  <= in_word;
            r_fwd_front <= o_we && (o_waddr == o_raddr_front);
            r_fwd_rear  <= o_we && (o_waddr == o_raddr_rear);
        end
    end

    assign front_word   = r_fwd_front ? r_fwd_word : i_rdata_front;
    assign rear_word    = r_fwd_rear  ? r_fwd_word : i_rdata_rear;
    assign front_ext    = 64'(signed'(front_word));
    assign rear_ext     = 64'(signed'(rear_word));
    assign o_front_item = r_stat.is_empty ? ITEM_NONE : front_ext[ITEM_W-1:0];
    assign o_rear_item  = r_stat.is_empty ? ITEM_NONE : rear_ext[ITEM_W-1:0];
    assign o_stat       = r_stat;
    assign o_resp_valid = (r_state == S_RESP);

    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("item count above capacity");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_head) < r_cap) && (CW'(r_tail) < r_cap))
        else $error("ring index outside capacity");

    a_gap_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == r_cap) |-> step_up(r_head, r_cap) == r_tail)
        else $error("head and tail gaps out of step");

    a_accept_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state == S_RESP))
        else $error("accepted beat produced no response");

endmodule

>>> tb/tb_circular_deque.sv
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking regression for the circular deque. Requests are driven on
// the valid/ready input channel and predicted by an in-bench ring-buffer
// model; every result beat is compared field by field against the oldest
// prediction. Covers directed corner cases, capacity sweeps including the
// zero and oversize settings, random push/pop traffic with bursty idling on
// both sides, a long output hold-off and a back-to-back tail.
// ----------------------------------------------------------------------------
module tb_circular_deque;
    import cdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH       = 16;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 6;
    localparam int REPORT_LIMIT     = 10;

    localparam logic [REQ_W-1:0] REQ_UNDEF_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNDEF_LAST  = 3'd7;

    typedef struct packed {
        logic               ok;
        logic [TOTAL_W-1:0] total;
        logic               empty;
        logic               full;
        logic [ITEM_W-1:0]  front;
        logic [ITEM_W-1:0]  rear;
    } t_deque_status;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CAP_W-1:0]   i_cfg_capacity;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [REQ_W-1:0]   i_req_type;
    logic [VALUE_W-1:0] i_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_ok;
    logic [TOTAL_W-1:0] o_item_total;
    logic               o_is_empty;
    logic               o_is_full;
    logic [ITEM_W-1:0]  o_front_item;
    logic [ITEM_W-1:0]  o_rear_item;

    // predictor state
    logic [VALUE_W-1:0] ring_word [RING_DEPTH];
    int                 cap_now;
    int                 front_gap;
    int                 rear_gap;
    int                 held;

    t_deque_status      pending_status[$];
    int                 mismatches;
    int                 quiet_cycles;
    bit                 idle_en;
    bit                 hold_request;

    circular_deque dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_capacity (i_cfg_capacity),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_item_total   (o_item_total),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_front_item   (o_front_item),
        .o_rear_item    (o_rear_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ring_up(input int i);
        return (i + 1 >= cap_now) ? 0 : i + 1;
    endfunction

    function automatic int ring_down(input int i);
        return (i == 0) ? cap_now - 1 : i - 1;
    endfunction

    function automatic void deque_apply(input logic [REQ_W-1:0] req,
                                        input logic [VALUE_W-1:0] word);
        t_deque_status s;
        s = '0;
        case (req)
            REQ_PUSH_FRONT: begin
                if (held < cap_now) begin
                    ring_word[front_gap] = word;
                    front_gap = ring_down(front_gap);
                    held++;
                    s.ok = 1'b1;
                end
            end
            REQ_PUSH_REAR: begin
                if (held < cap_now) begin
                    ring_word[rear_gap] = word;
                    rear_gap = ring_up(rear_gap);
                    held++;
                    s.ok = 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (held != 0) begin
                    front_gap = ring_up(front_gap);
                    held--;
                    s.ok = 1'b1;
                end
            end
            REQ_POP_REAR: begin
                if (held != 0) begin
                    rear_gap = ring_down(rear_gap);
                    held--;
                    s.ok = 1'b1;
                end
            end
            REQ_PEEK: s.ok = 1'b1;
            default: ;
        endcase
        s.total = held[TOTAL_W-1:0];
        s.empty = (held == 0);
        s.full  = (held == cap_now);
        s.front = (held == 0) ? ITEM_NONE : ring_word[ring_up(front_gap)];
        s.rear  = (held == 0) ? ITEM_NONE : ring_word[ring_down(rear_gap)];
        pending_status.push_back(s);
    endfunction

    function automatic void deque_clear(input logic [CAP_W-1:0] raw);
        if (raw == 0)
            cap_now = 1;
        else if (raw > RING_DEPTH)
            cap_now = RING_DEPTH;
        else
            cap_now = int'(raw);
        front_gap = cap_now - 1;
        rear_gap  = 0;
        held      = 0;
    endfunction

    function automatic void report_mismatch(input string field,
                                            input logic [31:0] want,
                                            input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] %s mismatch: expected %h, actual %h", $realtime, field, want, got);
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_results
        t_deque_status want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result beat with no request outstanding", $realtime);
            end else begin
                want = pending_status.pop_front();
                if (o_ok !== want.ok)
                    report_mismatch("ok", 32'(want.ok), 32'(o_ok));
                if (o_item_total !== want.total)
                    report_mismatch("item_total", 32'(want.total), 32'(o_item_total));
                if (o_is_empty !== want.empty)
                    report_mismatch("is_empty", 32'(want.empty), 32'(o_is_empty));
                if (o_is_full !== want.full)
                    report_mismatch("is_full", 32'(want.full), 32'(o_is_full));
                if (o_front_item !== want.front)
                    report_mismatch("front_item", want.front, o_front_item);
                if (o_rear_item !== want.rear)
                    report_mismatch("rear_item", want.rear, o_rear_item);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("circular_deque regression: fail");
            $finish;
        end
    end

    // result receiver: random stalls, calm stretches and the long hold-off
    initial begin : result_receiver
        int gap_left;
        int hold_left;
        int calm_left;
        gap_left    = 0;
        hold_left   = 0;
        calm_left   = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if (idle_en) begin
                    case ($urandom_range(0, 15))
                        0, 1: gap_left = $urandom_range(1, 6);
                        2: calm_left = $urandom_range(20, 80);
                        default: ;
                    endcase
                end
            end
        end
    end

    // one request beat; called and returns on a falling edge
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] word);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_req_type = req;
        i_value    = word;
        i_in_valid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        deque_apply(req, word);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] raw);
        wait_drained();
        i_cfg_capacity = raw;
        i_cfg_we       = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        deque_clear(raw);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // random traffic that swings between filling and draining
    task automatic send_mixed(input int count);
        int push_pct;
        int roll;
        push_pct = 75;
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 31)
                push_pct = (push_pct == 75) ? 20 : 75;
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR,
                             pick_word());
            else if (roll < 95)
                send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR, $urandom);
            else if (roll < 98)
                send_request(REQ_PEEK, $urandom);
            else
                send_request(REQ_W'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST)),
                             $urandom);
        end
    endtask

    task automatic test_empty_after_reset();
        send_request(REQ_PEEK, 32'h1234_5678);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_REAR, '1);
        send_request(REQ_UNDEF_FIRST, 32'hDEAD_BEEF);
        send_request(REQ_UNDEF_LAST, '0);
    endtask

    task automatic test_word_extremes();
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_REAR, 32'h8000_0000);
        send_request(REQ_PUSH_FRONT, '0);
        send_request(REQ_PUSH_REAR, '1);
        send_request(REQ_PEEK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_REAR, '0);
    endtask

    // zero capacity reads as one slot
    task automatic test_single_slot();
        set_capacity(5'd0);
        send_request(REQ_PUSH_REAR, 32'h0000_0001);
        send_request(REQ_PUSH_FRONT, 32'h0000_0002);
        send_request(REQ_PUSH_REAR, 32'h0000_0003);
        send_request(REQ_PEEK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_FRONT, '0);
    endtask

    task automatic test_capacity_sweep();
        logic [CAP_W-1:0] caps [10];
        caps = '{5'd31, 5'd1, 5'd2, 5'd16, 5'd0, 5'd7, 5'd17, 5'd3, 5'd16, 5'd12};
        foreach (caps[k]) begin
            set_capacity(caps[k]);
            send_mixed(190);
        end
    endtask

    // output held off while requests keep coming: input must back up
    task automatic test_output_hold();
        set_capacity(5'd16);
        idle_en      = 1'b0;
        hold_request = 1'b1;
        send_mixed(24);
        idle_en = 1'b1;
        wait_drained();
    endtask

    task automatic test_back_to_back();
        set_capacity(5'd4);
        idle_en = 1'b0;
        send_mixed(80);
        set_capacity(5'd16);
        send_mixed(80);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_capacity = '0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_PEEK;
        i_value        = '0;
        idle_en        = 1'b1;
        hold_request   = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        foreach (ring_word[k])
            ring_word[k] = '0;
        deque_clear(5'd16);
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_after_reset();
        test_word_extremes();
        test_single_slot();
        test_capacity_sweep();
        test_output_hold();
        test_back_to_back();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("circular_deque regression: pass");
        else
            $display("circular_deque regression: fail");
        $finish;
    end

endmodule
